/* sv/rlgr3_pkg.sv */
// Shared types and constants for the RLGR3 entropy decoder.
package rlgr3_pkg;

	localparam int CAP_W      = 13;
	localparam int PARAM_W    = 7;
	localparam int PARAM_MAX  = 80;
	localparam int PARAM_SHIFT = 3;
	localparam int RUN_UP     = 4;
	localparam int RUN_DOWN   = 6;
	localparam int MAG_DOWN   = 2;
	localparam int PAIR_STEP  = 6;
	localparam int PARAM_INIT = 8;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] coefficient;
		logic [10:0]        repeat_count;
		logic               end_marker;
		logic [CAP_W-1:0]   written_total;
	} out_item_t;

	typedef struct packed {
		logic     valid;
		in_item_t item;
	} byte_q_t;

endpackage

/* sv/rlgr3_front.sv */
// Input side: two-entry byte queue in front of the bit decoder.
module rlgr3_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rlgr3_pkg::in_item_t in_data,
	output rlgr3_pkg::byte_q_t  head,
	input  logic              pop
);
	import rlgr3_pkg::*;

	in_item_t    mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign in_ready   = (cnt_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* sv/rlgr3_back.sv */
// Bit-serial RLGR3 decode engine with registered result output.
module rlgr3_back #(
	parameter int CAPACITY_MAX = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rlgr3_pkg::byte_q_t          head,
	output logic                        pop,
	input  logic [rlgr3_pkg::CAP_W-1:0] capacity,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rlgr3_pkg::out_item_t        out_data
);
	import rlgr3_pkg::*;

	typedef enum logic [3:0] {
		PH_ESC_START, PH_ESC_MORE, PH_RUN_REM, PH_SIGN, PH_RL_UNARY,
		PH_RL_KBITS, PH_GR_UNARY, PH_GR_KBITS, PH_PAIR_BITS, PH_PAIR2
	} phase_t;

	function automatic logic [PARAM_W-1:0] param_add(input logic [PARAM_W-1:0] p,
			input logic [PARAM_W-1:0] up, input logic [2:0] down);
		logic [PARAM_W:0] s;
		s = {1'b0, p} + {1'b0, up};
		if (s > (PARAM_W+1)'(PARAM_MAX)) s = (PARAM_W+1)'(PARAM_MAX);
		return (s >= {5'd0, down}) ? PARAM_W'(s - {5'd0, down}) : '0;
	endfunction

	function automatic logic [15:0] ftms(input logic [17:0] v);
		logic [17:0] vp;
		vp = v + 18'd1;
		return v[0] ? (16'd0 - vp[16:1]) : v[16:1];
	endfunction

	phase_t            phase_q, phase_d;
	logic [PARAM_W-1:0] kp_q, kp_d, krp_q, krp_d;
	logic [15:0]       uc_q, uc_d, acc_q, acc_d, psum_q, psum_d;
	logic [4:0]        btr_q, btr_d;
	logic              sign_q, sign_d;
	logic [CAP_W-1:0]  wc_q, wc_d;
	logic [2:0]        bitcnt_q;
	logic              flush_q;
	out_item_t         out_q, res_d;
	logic              out_valid_q;

	logic              can_step, do_pair2, stop, do_end, have_bit, step, bit_v, eos;
	logic [3:0]        k, kr;
	logic              st_req, st_fire, gr_go, gr_rl, pair1, nxt;
	logic [15:0]       st_coef, gr_acc, lmag, m16, pair_v1;
	logic [10:0]       st_n, st_s;
	logic [CAP_W-1:0]  limit, avail;
	logic [16:0]       cmax, d17;
	logic [4:0]        nbits;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign k        = 4'(kp_q >> PARAM_SHIFT);
	assign kr       = 4'(krp_q >> PARAM_SHIFT);
	assign can_step = !out_valid_q || out_ready;
	assign do_pair2 = (phase_q == PH_PAIR2);
	assign stop     = (phase_q == PH_ESC_START) || (phase_q == PH_GR_UNARY && uc_q == 16'd0);
	assign do_end   = !do_pair2 && flush_q && stop;
	assign have_bit = !do_pair2 && (flush_q ? !stop : head.valid);
	assign step     = can_step && (do_pair2 || do_end || have_bit);
	assign bit_v    = flush_q ? 1'b0 : head.item.stream_byte[3'd7 - bitcnt_q];
	assign eos      = flush_q || (head.item.final_byte && bitcnt_q == 3'd7);
	assign pop      = step && have_bit && !flush_q && bitcnt_q == 3'd7;
	assign cmax     = 17'(CAPACITY_MAX);
	assign limit    = ({4'd0, capacity} < cmax) ? capacity : cmax[CAP_W-1:0];

	always_comb begin
		phase_d = phase_q; kp_d = kp_q; krp_d = krp_q; uc_d = uc_q; acc_d = acc_q;
		psum_d = psum_q; btr_d = btr_q; sign_d = sign_q;
		st_req = 1'b0; st_coef = '0; st_n = '0;
		gr_go = 1'b0; gr_rl = 1'b0; gr_acc = '0; pair1 = 1'b0; pair_v1 = '0; nxt = 1'b0;
		lmag = '0; m16 = '0; nbits = '0; d17 = '0;
		if (do_pair2) begin
			st_req = 1'b1; st_coef = psum_q; st_n = 11'd1; nxt = 1'b1;
		end else begin
			unique case (phase_q)
				PH_ESC_START, PH_ESC_MORE: begin
					if (!bit_v && !eos) begin
						st_req = 1'b1; st_n = 11'(16'd1 << k);
						kp_d = param_add(kp_q, PARAM_W'(RUN_UP), 3'd0);
						phase_d = PH_ESC_MORE;
					end else begin
						btr_d = {1'b0, k}; acc_d = '0;
						phase_d = (k != 4'd0) ? PH_RUN_REM : PH_SIGN;
					end
				end
				PH_RUN_REM: begin
					acc_d = {acc_q[14:0], bit_v}; btr_d = btr_q - 5'd1;
					if (btr_q == 5'd1) begin
						st_req = 1'b1; st_n = acc_d[10:0]; phase_d = PH_SIGN;
					end
				end
				PH_SIGN: begin
					sign_d = bit_v; uc_d = '0; phase_d = PH_RL_UNARY;
				end
				PH_RL_UNARY, PH_GR_UNARY: begin
					if (bit_v) begin
						if (uc_q != 16'hFFFF) uc_d = uc_q + 16'd1;
					end else begin
						phase_d = (phase_q == PH_RL_UNARY) ? PH_RL_KBITS : PH_GR_KBITS;
						btr_d = {1'b0, kr}; acc_d = '0;
						if (kr == 4'd0) begin
							gr_go = 1'b1; gr_rl = (phase_q == PH_RL_UNARY);
						end
					end
				end
				PH_RL_KBITS, PH_GR_KBITS: begin
					acc_d = {acc_q[14:0], bit_v}; btr_d = btr_q - 5'd1;
					if (btr_q == 5'd1) begin
						gr_go = 1'b1; gr_rl = (phase_q == PH_RL_KBITS); gr_acc = acc_d;
					end
				end
				PH_PAIR_BITS: begin
					acc_d = {acc_q[14:0], bit_v}; btr_d = btr_q - 5'd1;
					if (btr_q == 5'd1) begin
						pair1 = 1'b1; pair_v1 = acc_d;
					end
				end
				default: nxt = 1'b1;
			endcase
		end
		if (gr_go) begin
			lmag = (uc_q << kr) | gr_acc;
			if (uc_q == 16'd0) krp_d = param_add(krp_q, '0, 3'(MAG_DOWN));
			else if (uc_q != 16'd1)
				krp_d = param_add(krp_q, (uc_q > 16'(PARAM_MAX)) ? PARAM_W'(PARAM_MAX)
					: uc_q[PARAM_W-1:0], 3'd0);
			if (gr_rl) begin
				m16 = lmag + 16'd1;
				st_req = 1'b1; st_n = 11'd1; st_coef = sign_q ? (16'd0 - m16) : m16;
				kp_d = param_add(kp_q, '0, 3'(RUN_DOWN));
				nxt = 1'b1;
			end else begin
				psum_d = lmag;
				for (int i = 0; i < 16; i++) if (lmag[i]) nbits = 5'(i + 1);
				if (nbits == 5'd0) begin
					pair1 = 1'b1; pair_v1 = '0;
				end else begin
					phase_d = PH_PAIR_BITS; btr_d = nbits; acc_d = '0;
				end
			end
		end
		if (pair1) begin
			d17 = {1'b0, psum_d} - {1'b0, pair_v1};
			if (pair_v1 != 16'd0 && d17 != 17'd0)
				kp_d = param_add(kp_q, '0, 3'(PAIR_STEP));
			else if (pair_v1 == 16'd0 && d17 == 17'd0)
				kp_d = param_add(kp_q, PARAM_W'(PAIR_STEP), 3'd0);
			st_req = 1'b1; st_n = 11'd1; st_coef = ftms({2'b0, pair_v1});
			psum_d = ftms({d17[16], d17});
			phase_d = PH_PAIR2;
		end
		if (nxt) begin
			phase_d = ((kp_d >> PARAM_SHIFT) != '0) ? PH_ESC_START : PH_GR_UNARY;
			uc_d = '0; acc_d = '0; btr_d = '0;
		end
		avail   = limit - wc_q;
		st_fire = st_req && st_n != 11'd0 && wc_q < limit;
		st_s    = ({2'b0, st_n} < avail) ? st_n : avail[10:0];
		wc_d    = st_fire ? wc_q + CAP_W'(st_s) : wc_q;
		res_d.coefficient   = st_coef;
		res_d.repeat_count  = st_s;
		res_d.end_marker    = 1'b0;
		res_d.written_total = wc_d;
		if (do_end) begin
			res_d.coefficient   = '0;
			res_d.repeat_count  = '0;
			res_d.end_marker    = 1'b1;
			res_d.written_total = wc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ESC_START; kp_q <= PARAM_W'(PARAM_INIT); krp_q <= PARAM_W'(PARAM_INIT);
			uc_q <= '0; acc_q <= '0; psum_q <= '0; btr_q <= '0; sign_q <= 1'b0; wc_q <= '0;
			bitcnt_q <= '0; flush_q <= 1'b0; out_valid_q <= 1'b0; out_q <= '0;
		end else begin
			if (step && (st_fire || do_end)) begin
				out_q <= res_d; out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (step) begin
				if (do_end) begin
					phase_q <= PH_ESC_START; kp_q <= PARAM_W'(PARAM_INIT);
					krp_q <= PARAM_W'(PARAM_INIT); uc_q <= '0; acc_q <= '0; psum_q <= '0;
					btr_q <= '0; sign_q <= 1'b0; wc_q <= '0; flush_q <= 1'b0;
				end else begin
					phase_q <= phase_d; kp_q <= kp_d; krp_q <= krp_d; uc_q <= uc_d;
					acc_q <= acc_d; psum_q <= psum_d; btr_q <= btr_d; sign_q <= sign_d;
					wc_q <= wc_d;
				end
				if (have_bit && !flush_q) begin
					bitcnt_q <= bitcnt_q + 3'd1;
					if (bitcnt_q == 3'd7 && head.item.final_byte) flush_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* sv/rlgr3_entropy_decoder.sv */
// Top level of the RLGR3 entropy decoder.
// Coded bytes enter through a two-entry queue; the decode engine consumes one coded bit per
// clock while it is not stalled. The second value of a Golomb-Rice pair takes a step of its own
// with no coded bit, and after a final byte the engine feeds zero fill bits until it can stop,
// then emits the end marker. Each result sits in an output register; the engine stalls while
// that register is full and not taken, or while no coded byte is waiting. Capacity writes are always ready.
module rlgr3_entropy_decoder #(
	parameter int CAPACITY_MAX = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rlgr3_pkg::in_item_t         in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rlgr3_pkg::out_item_t        out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rlgr3_pkg::CAP_W-1:0] cfg_data
);
	import rlgr3_pkg::*;

	byte_q_t          head;
	logic             pop;
	logic [CAP_W-1:0] capacity_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(4096);
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	rlgr3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.head     (head),
		.pop      (pop)
	);

	rlgr3_back #(.CAPACITY_MAX(CAPACITY_MAX)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.capacity  (capacity_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* sv/rlgr3_checker.sv */
// Port-level checks for the RLGR3 entropy decoder, bound to the top level.
module rlgr3_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input rlgr3_pkg::in_item_t         in_data,
	input logic                        out_valid,
	input logic                        out_ready,
	input rlgr3_pkg::out_item_t        out_data,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic [rlgr3_pkg::CAP_W-1:0] cfg_data
);
	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.end_marker |->
			out_data.repeat_count == 11'd0 && out_data.coefficient == 16'sd0)
		else $error("end marker carries data");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.end_marker |->
			out_data.repeat_count != 11'd0 && out_data.repeat_count <= 11'd1024)
		else $error("bad repeat count");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.end_marker |->
			out_data.written_total >= 13'(out_data.repeat_count))
		else $error("written total below repeat count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");

endmodule

bind rlgr3_entropy_decoder rlgr3_checker u_checker (.*);
